// ===== rtl/core/rgh_pkg.sv =====
package rgh_pkg;

    // cordic datapath width, holds x, y and z with headroom
    localparam int XW = 34;

    localparam logic [33:0] ANG_Q46 = 34'd12281662764;
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(32'sh26DD3B6A);
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [19:0] RANGE_LIMIT = 20'd1000000;
    localparam logic signed [14:0] ELEV_LIMIT = 15'sd9000;
    localparam logic [24:0] EARTH_DIAM_M = 25'd17066000;
    localparam logic [39:0] EARTH_RADIUS_M = 40'd8533000;
    // floor(2^42 / 17066000), applied to the value shifted right by 10
    localparam logic [17:0] RECIP_M = 18'((64'd1 << 42) / 64'd17066000);

    typedef enum logic [1:0] {
        REG_RADAR_HEIGHT = 2'd0,
        REG_START_RANGE  = 2'd1,
        REG_GATE_SPACING = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic [19:0]          r;
        logic                 neg;
        logic                 clip;
    } cordic_t;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            24:      v = 32'h0000003F;
            25:      v = 32'h0000001F;
            26:      v = 32'h0000000F;
            27:      v = 32'h00000008;
            28:      v = 32'h00000004;
            29:      v = 32'h00000002;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rgh_in_if.sv =====
interface rgh_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] elevation_angle;
    logic [11:0]        gate_index;

    modport source (output valid, output elevation_angle, output gate_index, input ready);
    modport sink (input valid, input elevation_angle, input gate_index, output ready);
endinterface

// ===== rtl/core/rgh_out_if.sv =====
interface rgh_out_if;
    logic               valid;
    logic               ready;
    logic [19:0]        ground_range;
    logic signed [21:0] beam_height;
    logic [15:0]        cos_elevation;
    logic               range_clipped;

    modport source (
        output valid, output ground_range, output beam_height,
        output cos_elevation, output range_clipped, input ready
    );
    modport sink (
        input valid, input ground_range, input beam_height,
        input cos_elevation, input range_clipped, output ready
    );
endinterface

// ===== rtl/core/rgh_front.sv =====
module rgh_front
    import rgh_pkg::*;
#(
    parameter int MAX_GATES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    rgh_in_if.sink      gate_in,
    input  logic [19:0] slant_base,
    input  logic [13:0] slant_step,
    output logic        dn_valid,
    output cordic_t     dn_data,
    input  logic        dn_ready
);

    localparam logic [16:0] GATE_LIMIT = 17'(MAX_GATES);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1: clamp angle and gate
    logic [13:0] mag1_reg, mag1_next;
    logic        neg1_reg, neg1_next;
    logic [11:0] gate1_reg, gate1_next;
    // stage 2: angle to radians, gate times spacing
    logic [31:0] z2_reg, z2_next;
    logic [25:0] prod2_reg, prod2_next;
    logic        neg2_reg;
    // stage 3: slant range with saturation
    logic [19:0] r3_reg, r3_next;
    logic        clip3_reg, clip3_next;
    logic [31:0] z3_reg;
    logic        neg3_reg;

    logic signed [14:0] el_cl;
    logic [47:0]        zp;
    logic [26:0]        rsum;

    assign rdy3 = !v3_reg || dn_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign gate_in.ready = rdy1;

    always_comb
    begin
        if (gate_in.elevation_angle > ELEV_LIMIT)
        begin
            el_cl = ELEV_LIMIT;
        end
        else if (gate_in.elevation_angle < -ELEV_LIMIT)
        begin
            el_cl = -ELEV_LIMIT;
        end
        else
        begin
            el_cl = gate_in.elevation_angle;
        end
        neg1_next = el_cl[14];
        mag1_next = neg1_next ? 14'(-el_cl) : 14'(el_cl);
        // gates past the table fold onto its last entry
        if ({5'b0, gate_in.gate_index} >= GATE_LIMIT)
        begin
            gate1_next = 12'(GATE_LIMIT - 17'd1);
        end
        else
        begin
            gate1_next = gate_in.gate_index;
        end
    end

    assign zp         = 48'(mag1_reg) * 48'(ANG_Q46) + 48'd32768;
    assign z2_next    = zp[47:16];
    assign prod2_next = 26'(gate1_reg) * 26'(slant_step);

    assign rsum       = 27'(slant_base) + 27'(prod2_reg);
    assign clip3_next = rsum > 27'(RANGE_LIMIT);
    assign r3_next    = clip3_next ? RANGE_LIMIT : rsum[19:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= gate_in.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            gate1_reg <= gate1_next;
        end
        if (rdy2)
        begin
            z2_reg    <= z2_next;
            prod2_reg <= prod2_next;
            neg2_reg  <= neg1_reg;
        end
        if (rdy3)
        begin
            r3_reg    <= r3_next;
            clip3_reg <= clip3_next;
            z3_reg    <= z2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    assign dn_valid     = v3_reg;
    assign dn_data.x    = CORDIC_GAIN;
    assign dn_data.y    = '0;
    assign dn_data.z    = $signed({2'b00, z3_reg});
    assign dn_data.r    = r3_reg;
    assign dn_data.neg  = neg3_reg;
    assign dn_data.clip = clip3_reg;

endmodule

// ===== rtl/core/rgh_cordic_stage.sv =====
module rgh_cordic_stage
    import rgh_pkg::*;
#(
    parameter int unsigned STAGE = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  cordic_t up_data,
    output logic    up_ready,
    output logic    dn_valid,
    output cordic_t dn_data,
    input  logic    dn_ready
);

    localparam logic signed [XW-1:0] ANGLE = $signed(XW'(atan_q30(STAGE)));

    logic                 v_reg;
    cordic_t              d_reg, d_next;
    logic signed [XW-1:0] xi, yi, zi, dx, dy;

    assign up_ready = !v_reg || dn_ready;

    assign xi = up_data.x;
    assign yi = up_data.y;
    assign zi = up_data.z;
    // arithmetic shift gives the floor rounding
    assign dx = yi >>> STAGE;
    assign dy = xi >>> STAGE;

    always_comb
    begin
        d_next = up_data;
        if (!zi[XW-1])
        begin
            d_next.x = xi - dx;
            d_next.y = yi + dy;
            d_next.z = zi - ANGLE;
        end
        else
        begin
            d_next.x = xi + dx;
            d_next.y = yi - dy;
            d_next.z = zi + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            d_reg <= d_next;
        end
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

// ===== rtl/core/rgh_back.sv =====
module rgh_back
    import rgh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  cordic_t            up_data,
    output logic               up_ready,
    input  logic signed [14:0] radar_height,
    rgh_out_if.source          result
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: clamp cos and sin to the unit range
    logic [30:0] c1_reg, c1_next, s1_reg, s1_next;
    logic [19:0] r1_reg;
    logic        neg1_reg, clip1_reg;
    // stage 2: products with slant range
    logic [19:0] gr2_reg, gr2_next, sm2_reg, sm2_next;
    logic [15:0] cos2_reg, cos2_next;
    logic [39:0] rr2_reg, rr2_next;
    logic        neg2_reg, clip2_reg;
    // stage 3: quotient estimate, height without curvature
    logic [39:0]        n3_reg, n3_next;
    logic [15:0]        q3_reg, q3_next;
    logic signed [21:0] hp3_reg, hp3_next;
    logic [19:0]        gr3_reg;
    logic [15:0]        cos3_reg;
    logic               clip3_reg;
    // stage 4: quotient back times divisor
    logic [40:0]        qd4_reg, qd4_next;
    logic [39:0]        n4_reg;
    logic [15:0]        q4_reg;
    logic signed [21:0] hp4_reg;
    logic [19:0]        gr4_reg;
    logic [15:0]        cos4_reg;
    logic               clip4_reg;
    // stage 5: output word
    logic [19:0]        gr5_reg;
    logic signed [21:0] h5_reg, h5_next;
    logic [15:0]        cos5_reg;
    logic               clip5_reg;

    logic [50:0]        grp, smp;
    logic [31:0]        cosp;
    logic [47:0]        qp;
    logic signed [21:0] rh22, sm22;
    logic [40:0]        rem;
    logic [15:0]        curv;

    assign rdy5 = !v5_reg || result.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign up_ready = rdy1;

    always_comb
    begin
        if (up_data.x < 0)
        begin
            c1_next = '0;
        end
        else if (up_data.x > $signed(XW'(ONE_Q30)))
        begin
            c1_next = ONE_Q30;
        end
        else
        begin
            c1_next = up_data.x[30:0];
        end
        if (up_data.y < 0)
        begin
            s1_next = '0;
        end
        else if (up_data.y > $signed(XW'(ONE_Q30)))
        begin
            s1_next = ONE_Q30;
        end
        else
        begin
            s1_next = up_data.y[30:0];
        end
    end

    assign grp       = 51'(r1_reg) * 51'(c1_reg) + 51'(32'h2000_0000);
    assign smp       = 51'(r1_reg) * 51'(s1_reg) + 51'(32'h2000_0000);
    assign cosp      = 32'(c1_reg) + 32'h0000_4000;
    assign gr2_next  = grp[49:30];
    assign sm2_next  = smp[49:30];
    assign cos2_next = cosp[30:15];
    assign rr2_next  = 40'(r1_reg) * 40'(r1_reg);

    // curvature r^2 / (2 Re), rounded: estimate low by at most one
    assign n3_next  = rr2_reg + EARTH_RADIUS_M;
    assign qp       = 48'(n3_next[39:10]) * 48'(RECIP_M);
    assign q3_next  = qp[47:32];
    assign rh22     = 22'(radar_height);
    assign sm22     = $signed({2'b00, sm2_reg});
    assign hp3_next = neg2_reg ? rh22 - sm22 : rh22 + sm22;

    assign qd4_next = 41'(q3_reg) * 41'(EARTH_DIAM_M);

    assign rem     = 41'(n4_reg) - qd4_reg;
    assign curv    = (rem >= 41'(EARTH_DIAM_M)) ? q4_reg + 16'd1 : q4_reg;
    assign h5_next = hp4_reg + $signed({6'b0, curv});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            c1_reg    <= c1_next;
            s1_reg    <= s1_next;
            r1_reg    <= up_data.r;
            neg1_reg  <= up_data.neg;
            clip1_reg <= up_data.clip;
        end
        if (rdy2)
        begin
            gr2_reg   <= gr2_next;
            sm2_reg   <= sm2_next;
            cos2_reg  <= cos2_next;
            rr2_reg   <= rr2_next;
            neg2_reg  <= neg1_reg;
            clip2_reg <= clip1_reg;
        end
        if (rdy3)
        begin
            n3_reg    <= n3_next;
            q3_reg    <= q3_next;
            hp3_reg   <= hp3_next;
            gr3_reg   <= gr2_reg;
            cos3_reg  <= cos2_reg;
            clip3_reg <= clip2_reg;
        end
        if (rdy4)
        begin
            qd4_reg   <= qd4_next;
            n4_reg    <= n3_reg;
            q4_reg    <= q3_reg;
            hp4_reg   <= hp3_reg;
            gr4_reg   <= gr3_reg;
            cos4_reg  <= cos3_reg;
            clip4_reg <= clip3_reg;
        end
        if (rdy5)
        begin
            gr5_reg   <= gr4_reg;
            h5_reg    <= h5_next;
            cos5_reg  <= cos4_reg;
            clip5_reg <= clip4_reg;
        end
    end

    assign result.valid         = v5_reg;
    assign result.ground_range  = gr5_reg;
    assign result.beam_height   = h5_reg;
    assign result.cos_elevation = cos5_reg;
    assign result.range_clipped = clip5_reg;

`ifndef SYNTHESIS
    // one correction step must be enough for the quotient estimate
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (41'(n4_reg) - qd4_reg) < (41'(EARTH_DIAM_M) << 1))
        else $error("curvature estimate off by more than one");

    a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !rdy5) |=> (v4_reg && $stable(q4_reg) && $stable(hp4_reg)))
        else $error("stalled word lost in stage 4");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (cos5_reg <= 16'd32768))
        else $error("cos out of range");

    a_ground_range: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (gr5_reg <= RANGE_LIMIT))
        else $error("ground range above slant range limit");
`endif

endmodule

// ===== rtl/core/radar_gate_height_and_ground_range_top.sv =====
// channel   | dir | word                                             | handshake
// gate_in   | in  | elevation_angle[14:0] s, gate_index[11:0]        | valid/ready
// geo_out   | out | ground_range[19:0], beam_height[21:0] s,         | valid/ready
//           |     | cos_elevation[15:0], range_clipped               |
// apb       | in  | paddr[3:2] selects register, 32 bit data         | psel/penable
//
// one word per cycle sustained while geo_out is ready
// the cordic chain does one rotation per register stage
// reset clears all stage valid bits and loads the register defaults
// a stalled output holds only the full stages behind it; empty stages keep filling
module radar_gate_height_and_ground_range_top
    import rgh_pkg::*;
#(
    parameter int MAX_GATES     = 4096,
    parameter int CORDIC_STAGES = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rgh_in_if.sink      gate_in,
    rgh_out_if.source   geo_out
);

    logic signed [14:0] radar_height_reg;
    logic [19:0]        slant_base_reg;
    logic [13:0]        slant_step_reg;
    reg_index_t         reg_sel;
    logic               wr_en;

    cordic_t cdata [CORDIC_STAGES+1];
    logic    cval  [CORDIC_STAGES+1];
    logic    crdy  [CORDIC_STAGES+1];

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radar_height_reg <= '0;
            slant_base_reg   <= '0;
            slant_step_reg   <= 14'd250;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_RADAR_HEIGHT: radar_height_reg <= $signed(pwdata[14:0]);
                REG_START_RANGE:  slant_base_reg   <= pwdata[19:0];
                REG_GATE_SPACING: slant_step_reg   <= pwdata[13:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RADAR_HEIGHT: prdata = {17'b0, radar_height_reg};
            REG_START_RANGE:  prdata = {12'b0, slant_base_reg};
            REG_GATE_SPACING: prdata = {18'b0, slant_step_reg};
            default:          prdata = '0;
        endcase
    end

    rgh_front #(
        .MAX_GATES(MAX_GATES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .gate_in    (gate_in),
        .slant_base (slant_base_reg),
        .slant_step (slant_step_reg),
        .dn_valid   (cval[0]),
        .dn_data    (cdata[0]),
        .dn_ready   (crdy[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        rgh_cordic_stage #(
            .STAGE(k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cval[k]),
            .up_data  (cdata[k]),
            .up_ready (crdy[k]),
            .dn_valid (cval[k+1]),
            .dn_data  (cdata[k+1]),
            .dn_ready (crdy[k+1])
        );
    end

    rgh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (cval[CORDIC_STAGES]),
        .up_data      (cdata[CORDIC_STAGES]),
        .up_ready     (crdy[CORDIC_STAGES]),
        .radar_height (radar_height_reg),
        .result       (geo_out)
    );

endmodule

// ===== bench/radar_gate_height_and_ground_range_top_tb.sv =====
module radar_gate_height_and_ground_range_top_tb
    import rgh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GATES      = 4096;
    localparam int CORDIC_STAGES  = 24;
    localparam int ROTATIONS      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LATENCY        = 3 + CORDIC_STAGES + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_WORDS    = 50;
    localparam int PRESSURE_PHASE = 4;
    localparam int STEADY_PHASE   = 2;

    // register index that decodes to nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint ELEV_MAX       = 9000;
    localparam longint RAD_PER_CDEG   = 64'sd12281662764;
    localparam longint GAIN_Q30       = 64'sh26DD3B6A;
    localparam longint UNIT_Q30       = 64'sd1073741824;
    localparam longint SLANT_MAX      = 64'sd1000000;
    localparam longint EARTH_2R       = 64'sd17066000;
    localparam longint EARTH_R        = 64'sd8533000;

    localparam longint ARCTAN_Q30 [32] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
        64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
        64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
        64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
        64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F, 64'sh0000003F,
        64'sh0000001F, 64'sh0000000F, 64'sh00000008, 64'sh00000004, 64'sh00000002,
        64'sh00000001, 64'sh00000000
    };

    typedef struct packed {
        logic signed [14:0] elevation_angle;
        logic [11:0]        gate_index;
    } gate_word_t;

    typedef struct packed {
        logic [19:0]        ground_range;
        logic signed [21:0] beam_height;
        logic [15:0]        cos_elevation;
        logic               range_clipped;
    } geo_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgh_in_if  gate_in_if ();
    rgh_out_if geo_out_if ();

    radar_gate_height_and_ground_range_top #(
        .MAX_GATES     (MAX_GATES),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gate_in (gate_in_if),
        .geo_out (geo_out_if)
    );

    // shadow copies of the block's registers
    logic signed [14:0] height_setting;
    logic [19:0]        start_setting;
    logic [13:0]        spacing_setting;

    gate_word_t pending_words [$];
    geo_word_t  expected_geo [$];

    logic hold_sender;
    logic steady;
    int   mismatches;
    int   words_sent;
    int   words_checked;
    int   clipped_seen;
    int   settings_used;
    int   send_gap;
    int   recv_stall;
    int   quiet_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic geo_word_t predict_geometry(input gate_word_t w);
        longint    el;
        longint    mag;
        longint    z;
        longint    x;
        longint    y;
        longint    dx;
        longint    dy;
        longint    gate;
        longint    slant;
        longint    ground;
        longint    rise;
        longint    bulge;
        longint    height;
        longint    cos_q15;
        logic      neg;
        logic      clip;
        int        i;
        geo_word_t g;
        el = longint'(w.elevation_angle);
        if (el > ELEV_MAX)
            el = ELEV_MAX;
        if (el < -ELEV_MAX)
            el = -ELEV_MAX;
        neg = el < 0;
        mag = neg ? -el : el;
        z = (mag * RAD_PER_CDEG + 64'sd32768) >>> 16;
        x = GAIN_Q30;
        y = 0;
        for (i = 0; i < ROTATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q30[i];
            end
        end
        if (x < 0)
            x = 0;
        if (x > UNIT_Q30)
            x = UNIT_Q30;
        if (y < 0)
            y = 0;
        if (y > UNIT_Q30)
            y = UNIT_Q30;
        // gates past the table fold onto its last entry
        gate = longint'(w.gate_index);
        if (gate >= MAX_GATES)
            gate = MAX_GATES - 1;
        slant = longint'(start_setting) + gate * longint'(spacing_setting);
        clip = slant > SLANT_MAX;
        if (clip)
            slant = SLANT_MAX;
        ground = (slant * x + 64'sd536870912) >>> 30;
        rise = (slant * y + 64'sd536870912) >>> 30;
        // 4/3 earth curvature term, rounded to nearest
        bulge = (slant * slant + EARTH_R) / EARTH_2R;
        height = longint'(height_setting) + (neg ? -rise : rise) + bulge;
        cos_q15 = (x + 64'sd16384) >>> 15;
        g.ground_range = ground[19:0];
        g.beam_height = height[21:0];
        g.cos_elevation = cos_q15[15:0];
        g.range_clipped = clip;
        return g;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("geo word %0d: %s is %0d, predicted %0d", words_checked, what, got, want);
        mismatches++;
    endtask

    // sender: holds a presented word until it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gate_in_if.valid <= 1'b0;
            gate_in_if.elevation_angle <= '0;
            gate_in_if.gate_index <= '0;
            send_gap = 0;
        end
        else if (!(gate_in_if.valid && !gate_in_if.ready))
        begin
            if (gate_in_if.valid)
            begin
                expected_geo.push_back(predict_geometry(pending_words[0]));
                void'(pending_words.pop_front());
                words_sent++;
                send_gap = steady ? 0 : pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                gate_in_if.valid <= 1'b0;
            end
            else if (pending_words.size() != 0 && !hold_sender)
            begin
                gate_in_if.valid <= 1'b1;
                gate_in_if.elevation_angle <= pending_words[0].elevation_angle;
                gate_in_if.gate_index <= pending_words[0].gate_index;
            end
            else
            begin
                gate_in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: checks each geo word against the oldest prediction
    always @(posedge clk)
    begin
        geo_word_t want;
        if (!rst_n)
        begin
            geo_out_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (geo_out_if.valid && geo_out_if.ready)
            begin
                if (expected_geo.size() == 0)
                begin
                    report_mismatch("gate words waiting", 0, 1);
                end
                else
                begin
                    want = expected_geo.pop_front();
                    if (geo_out_if.ground_range !== want.ground_range)
                        report_mismatch("ground_range", geo_out_if.ground_range,
                                        want.ground_range);
                    if (geo_out_if.beam_height !== want.beam_height)
                        report_mismatch("beam_height", geo_out_if.beam_height,
                                        want.beam_height);
                    if (geo_out_if.cos_elevation !== want.cos_elevation)
                        report_mismatch("cos_elevation", geo_out_if.cos_elevation,
                                        want.cos_elevation);
                    if (geo_out_if.range_clipped !== want.range_clipped)
                        report_mismatch("range_clipped", geo_out_if.range_clipped,
                                        want.range_clipped);
                    if (want.range_clipped)
                        clipped_seen++;
                end
                words_checked++;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                geo_out_if.ready <= 1'b0;
            end
            else
            begin
                geo_out_if.ready <= 1'b1;
                recv_stall = steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((gate_in_if.valid && gate_in_if.ready) || (geo_out_if.valid && geo_out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RADAR_HEIGHT: height_setting = value[14:0];
            REG_START_RANGE:  start_setting = value[19:0];
            REG_GATE_SPACING: spacing_setting = value[13:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int height, input int start, input int spacing);
        apb_write(REG_RADAR_HEIGHT, 32'(height));
        apb_write(REG_START_RANGE, 32'(start));
        apb_write(REG_GATE_SPACING, 32'(spacing));
        settings_used++;
    endtask

    task automatic push_word(input int el, input int gate);
        gate_word_t w;
        w.elevation_angle = 15'(el);
        w.gate_index = 12'(gate);
        pending_words.push_back(w);
    endtask

    // let every queued word through and the pipeline empty out
    task automatic drain();
        while (pending_words.size() != 0 || expected_geo.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic random_settings();
        int roll;
        int height;
        int start;
        int spacing;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            height = -500;
        else if (roll < 30)
            height = 9000;
        else if (roll < 40)
            height = int'($urandom_range(0, 32767)) - 16384;
        else
            height = int'($urandom_range(0, 9500)) - 500;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            start = 0;
        else if (roll < 25)
            start = 1000000;
        else if (roll < 35)
            start = $urandom_range(0, 20'hFFFFF);
        else
            start = $urandom_range(0, 200000);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            spacing = 0;
        else if (roll < 20)
            spacing = 1;
        else if (roll < 30)
            spacing = 10000;
        else if (roll < 40)
            spacing = $urandom_range(0, 14'h3FFF);
        else
            spacing = $urandom_range(1, 250);
        apply_settings(height, start, spacing);
    endtask

    task automatic push_random_word();
        int roll;
        int el;
        int gate;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            el = 9000;
        else if (roll < 8)
            el = -9000;
        else if (roll < 16)
            el = int'($urandom_range(0, 32767)) - 16384;
        else
            el = int'($urandom_range(0, 18000)) - 9000;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            gate = 0;
        else if (roll < 10)
            gate = MAX_GATES - 1;
        else
            gate = $urandom_range(0, 12'hFFF);
        push_word(el, gate);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gate_in_if.valid = 1'b0;
        gate_in_if.elevation_angle = '0;
        gate_in_if.gate_index = '0;
        geo_out_if.ready = 1'b0;
        hold_sender = 1'b0;
        steady = 1'b1;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        clipped_seen = 0;
        settings_used = 1;
        quiet_cycles = 0;
        height_setting = '0;
        start_setting = '0;
        spacing_setting = 14'd250;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: elevation extremes, saturation past ninety degrees, far gates clip
        push_word(0, 0);
        push_word(9000, 0);
        push_word(-9000, 0);
        push_word(16383, 100);
        push_word(-16384, 100);
        push_word(1, 1);
        push_word(-1, 1);
        push_word(4500, 2000);
        push_word(-4500, 2000);
        push_word(9000, MAX_GATES - 1);
        push_word(0, MAX_GATES - 1);
        push_word(-8999, 10);
        drain();

        steady = 1'b0;
        apply_settings(-500, 0, 1);
        push_word(0, 0);
        push_word(9000, MAX_GATES - 1);
        push_word(-9000, MAX_GATES - 1);
        push_word(4500, 0);
        drain();

        // start range beyond the one-million limit clips every gate
        apply_settings(9000, 20'hFFFFF, 10000);
        push_word(0, 0);
        push_word(-9000, 0);
        push_word(9000, MAX_GATES - 1);
        drain();

        // zero spacing puts every gate at the start range; the spare index is ignored
        apply_settings(-16384, 1000000, 0);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        push_word(0, 0);
        push_word(-9000, MAX_GATES - 1);
        push_word(9000, 123);
        push_word(16383, MAX_GATES - 1);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady = (phase == STEADY_PHASE);
            if (phase == RANDOM_PHASES - 1)
                apply_settings(16383, 0, 1);
            else
                random_settings();
            for (n = 0; n < PHASE_WORDS; n++)
                push_random_word();
            if (phase == PRESSURE_PHASE)
            begin
                while (pending_words.size() > PHASE_WORDS / 2)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (expected_geo.size() != 0 || gate_in_if.valid)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        $display("%0d gate words sent over %0d register settings, %0d of them range-clipped",
                 words_sent, settings_used, clipped_seen);
        $display("%0d geo words checked, %0d field mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== radar_gate_height_and_ground_range_top.f =====
rtl/core/rgh_pkg.sv
rtl/core/rgh_in_if.sv
rtl/core/rgh_out_if.sv
rtl/core/rgh_front.sv
rtl/core/rgh_cordic_stage.sv
rtl/core/rgh_back.sv
rtl/core/radar_gate_height_and_ground_range_top.sv
bench/radar_gate_height_and_ground_range_top_tb.sv
